// ----- rtl/gwfag_pkg.sv -----
`timescale 1ns / 1ps

package gwfag_pkg;

  localparam int DEF_INDEX_BITS = 32;
  localparam int OUT_CUBE       = 16;
  localparam int OUT_CUBE_LOG2  = 4;

  // Cycles from a config write (or reset) until the derived strides are stable
  localparam logic [3:0] SETTLE_CYCLES = 4'd12;

  // Config register indexes
  localparam logic [2:0] REG_OUT_PER_GROUP = 3'd0;
  localparam logic [2:0] REG_IN_CHANNELS   = 3'd1;
  localparam logic [2:0] REG_KERNEL_ROWS   = 3'd2;
  localparam logic [2:0] REG_KERNEL_COLS   = 3'd3;
  localparam logic [2:0] REG_GROUP_COUNT   = 3'd4;
  localparam logic [2:0] REG_WIDE_CUBE     = 3'd5;
  localparam logic [2:0] REG_PLAIN_LAYOUT  = 3'd6;
  localparam logic [2:0] REG_DIRECTION     = 3'd7;

  // Plain layout codes
  localparam logic [1:0] LAYOUT_HWCN = 2'd0;
  localparam logic [1:0] LAYOUT_NCHW = 2'd1;
  localparam logic [1:0] LAYOUT_NHWC = 2'd2;

  localparam logic [12:0] COUNT_MAX = 13'd4096;

  // Strides of the reset shape (all sizes 1, K = 16, NCHW)
  localparam int RST_S1      = 256;
  localparam int RST_S2      = 256;
  localparam int RST_S3C     = 241;
  localparam int RST_S4      = 256;
  localparam int RST_GSTEP   = 17;
  localparam int RST_GSTEP_C = 257;
  localparam int RST_R       = 1;

  function automatic logic [12:0] clamp_count(input logic [12:0] v);
    logic [12:0] r;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > COUNT_MAX) begin
      r = COUNT_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [3:0] trail_zeros(input logic [12:0] v);
    logic [3:0] tz;
    tz = 4'd0;
    for (int i = 12; i >= 0; i--) begin
      if (v[i]) tz = 4'(i);
    end
    return tz;
  endfunction

endpackage

// ----- rtl/grouped_weight_fractal_address_gen_unit.sv -----
`timescale 1ns / 1ps

// Each accepted item's index pair is registered onto the output in the next cycle.
// Throughput: one item per cycle unless the output stalls; indices advance by adding
// precomputed strides. After reset and after every config write, input ready stays
// low while the stride pipeline (one multiply per stage) settles.
// Reset (rst, synchronous): config to defaults, counters to the first element,
// shape latched to the default shape, output empty.
module grouped_weight_fractal_address_gen_unit
  import gwfag_pkg::*;
#(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] read_index, [63:32] write_index
  output logic        m_axis_tlast
);

  localparam int IB = INDEX_BITS;

  // ---------------- config registers ----------------
  logic [12:0] out_per_group, in_channels, group_count;
  logic [7:0]  kernel_rows, kernel_cols;
  logic        wide_cube, direction;
  logic [1:0]  plain_layout;
  logic [3:0]  settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_per_group <= 13'd1;
      in_channels   <= 13'd1;
      kernel_rows   <= 8'd1;
      kernel_cols   <= 8'd1;
      group_count   <= 13'd1;
      wide_cube     <= 1'b0;
      plain_layout  <= LAYOUT_NCHW;
      direction     <= 1'b0;
      settle        <= SETTLE_CYCLES;
    end else begin
      if (cfg_write) begin
        settle <= SETTLE_CYCLES;
        case (cfg_index)
          REG_OUT_PER_GROUP: out_per_group <= cfg_data;
          REG_IN_CHANNELS:   in_channels   <= cfg_data;
          REG_KERNEL_ROWS:   kernel_rows   <= cfg_data[7:0];
          REG_KERNEL_COLS:   kernel_cols   <= cfg_data[7:0];
          REG_GROUP_COUNT:   group_count   <= cfg_data;
          REG_WIDE_CUBE:     wide_cube     <= cfg_data[0];
          REG_PLAIN_LAYOUT:  plain_layout  <= cfg_data[1:0];
          REG_DIRECTION:     direction     <= cfg_data[0];
          default: ;
        endcase
      end else if (settle != 4'd0) begin
        settle <= settle - 4'd1;
      end
    end
  end

  // ---------------- stride derivation pipeline ----------------
  // Free running; later stages read earlier ones directly since all are
  // stable once settle has run out.
  logic [12:0] d1_co, d1_ci, d1_g;
  logic [7:0]  d1_h, d1_w;
  logic        d1_wide, d1_dir;
  logic [1:0]  d1_lay;
  logic [5:0]  d1_kval;

  logic [5:0]  d2_e;
  logic [15:0] d2_hw;
  logic [20:0] d2_wci;
  logic [25:0] d2_nd;

  logic [18:0] d3_eci, d3_eco;
  logic [28:0] d3_cihw;
  logic [38:0] d3_cind;

  logic [13:0] d4_c1;
  logic [19:0] d4_cout_opt;
  logic [8:0]  d4_q;
  logic [4:0]  d4_r;
  logic [17:0] d4_cok;
  logic [46:0] d4_wcind;
  logic [41:0] d4_gpl;

  logic [IB-1:0] d5_s1, d5_pn, d5_pw, d5_ph, d5_pc, d5_pg;
  logic [IB-1:0] d6_s2, d7_s3, d8_s4, d8_qs3, d8_s3c, d9_gstep, d10_gstep_c;

  logic [3:0] tz_ci, tz_co, tzc_ci, tzc_co, kshift;
  logic [5:0] a_fac, b_fac, m_fac;

  always_comb begin
    kshift = d1_wide ? 4'd5 : 4'd4;
    tz_ci  = trail_zeros(d1_ci);
    tz_co  = trail_zeros(d1_co);
    tzc_ci = (tz_ci > kshift) ? kshift : tz_ci;
    tzc_co = (tz_co > 4'(OUT_CUBE_LOG2)) ? 4'(OUT_CUBE_LOG2) : tz_co;
    a_fac  = d1_kval >> tzc_ci;
    b_fac  = 6'(OUT_CUBE) >> tzc_co;
    m_fac  = (a_fac > b_fac) ? a_fac : b_fac;
  end

  always_ff @(posedge clk) begin
    d1_co   <= clamp_count(out_per_group);
    d1_ci   <= clamp_count(in_channels);
    d1_g    <= clamp_count(group_count);
    d1_h    <= (kernel_rows == 8'd0) ? 8'd1 : kernel_rows;
    d1_w    <= (kernel_cols == 8'd0) ? 8'd1 : kernel_cols;
    d1_wide <= wide_cube;
    d1_kval <= wide_cube ? 6'd32 : 6'd16;
    d1_lay  <= plain_layout;
    d1_dir  <= direction;

    d2_e   <= ({7'd0, m_fac} > d1_g) ? d1_g[5:0] : m_fac;
    d2_hw  <= d1_h * d1_w;
    d2_wci <= d1_w * d1_ci;
    d2_nd  <= d1_g * d1_co;

    d3_eci  <= d2_e * d1_ci;
    d3_eco  <= d2_e * d1_co;
    d3_cihw <= d1_ci * d2_hw;
    d3_cind <= d1_ci * d2_nd;

    d4_c1       <= 14'((20'(d3_eci) + 20'(d1_kval) - 20'd1) >> kshift);
    d4_cout_opt <= ((20'(d3_eco) + 20'(OUT_CUBE - 1)) >> OUT_CUBE_LOG2) << OUT_CUBE_LOG2;
    d4_q        <= 9'(d1_ci >> kshift);
    d4_r        <= d1_ci[4:0] & 5'(d1_kval - 6'd1);
    d4_cok      <= 18'(d1_co) << kshift;
    d4_wcind    <= d1_w * d3_cind;
    d4_gpl      <= d1_co * d3_cihw;

    d5_s1 <= IB'(25'(d4_cout_opt) << kshift);
    case (d1_lay)
      LAYOUT_HWCN: begin
        d5_pn <= IB'(1);
        d5_pw <= IB'(d3_cind);
        d5_ph <= IB'(d4_wcind);
        d5_pc <= IB'(d2_nd);
        d5_pg <= IB'(d1_co);
      end
      LAYOUT_NCHW: begin
        d5_pn <= IB'(d3_cihw);
        d5_pw <= IB'(1);
        d5_ph <= IB'(d1_w);
        d5_pc <= IB'(d2_hw);
        d5_pg <= IB'(d4_gpl);
      end
      LAYOUT_NHWC: begin
        d5_pn <= IB'(d3_cihw);
        d5_pw <= IB'(d1_ci);
        d5_ph <= IB'(d2_wci);
        d5_pc <= IB'(1);
        d5_pg <= IB'(d4_gpl);
      end
      default: begin
        d5_pn <= '0;
        d5_pw <= '0;
        d5_ph <= '0;
        d5_pc <= '0;
        d5_pg <= '0;
      end
    endcase

    d6_s2  <= IB'(d1_w * d5_s1);
    d7_s3  <= IB'(d1_h * d6_s2);
    d8_s4  <= IB'(d4_c1 * d7_s3);
    d8_qs3 <= IB'(d4_q * d7_s3);
    d8_s3c <= d7_s3 - IB'(d1_kval - 6'd1);
    d9_gstep    <= d8_qs3 + IB'(d4_r) + IB'(d4_cok);
    d10_gstep_c <= d9_gstep + d7_s3 - IB'(d1_kval);
  end

  // ---------------- latched shape ----------------
  logic          l_wide, l_dir;
  logic [11:0]   l_co_m1, l_ci_m1, l_g_m1;
  logic [7:0]    l_h_m1, l_w_m1;
  logic [4:0]    l_e_m1, l_r;
  logic [IB-1:0] l_s1, l_s2, l_s3c, l_s4, l_gstep, l_gstep_c;
  logic [IB-1:0] l_pn, l_pw, l_ph, l_pc, l_pg;

  logic          restart, accept;
  logic          e_wide, e_dir;
  logic [11:0]   e_co_m1, e_ci_m1, e_g_m1;
  logic [7:0]    e_h_m1, e_w_m1;
  logic [4:0]    e_e_m1, e_r;
  logic [IB-1:0] e_s1, e_s2, e_s3c, e_s4, e_gstep, e_gstep_c;
  logic [IB-1:0] e_pn, e_pw, e_ph, e_pc, e_pg;

  assign restart       = s_axis_tdata[0];
  assign s_axis_tready = (settle == 4'd0) && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // a restart item already runs on the freshly derived shape
  always_comb begin
    if (restart) begin
      e_wide    = d1_wide;
      e_dir     = d1_dir;
      e_co_m1   = 12'(d1_co - 13'd1);
      e_ci_m1   = 12'(d1_ci - 13'd1);
      e_g_m1    = 12'(d1_g - 13'd1);
      e_h_m1    = d1_h - 8'd1;
      e_w_m1    = d1_w - 8'd1;
      e_e_m1    = 5'(d2_e - 6'd1);
      e_r       = d4_r;
      e_s1      = d5_s1;
      e_s2      = d6_s2;
      e_s3c     = d8_s3c;
      e_s4      = d8_s4;
      e_gstep   = d9_gstep;
      e_gstep_c = d10_gstep_c;
      e_pn      = d5_pn;
      e_pw      = d5_pw;
      e_ph      = d5_ph;
      e_pc      = d5_pc;
      e_pg      = d5_pg;
    end else begin
      e_wide    = l_wide;
      e_dir     = l_dir;
      e_co_m1   = l_co_m1;
      e_ci_m1   = l_ci_m1;
      e_g_m1    = l_g_m1;
      e_h_m1    = l_h_m1;
      e_w_m1    = l_w_m1;
      e_e_m1    = l_e_m1;
      e_r       = l_r;
      e_s1      = l_s1;
      e_s2      = l_s2;
      e_s3c     = l_s3c;
      e_s4      = l_s4;
      e_gstep   = l_gstep;
      e_gstep_c = l_gstep_c;
      e_pn      = l_pn;
      e_pw      = l_pw;
      e_ph      = l_ph;
      e_pc      = l_pc;
      e_pg      = l_pg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l_wide    <= 1'b0;
      l_dir     <= 1'b0;
      l_co_m1   <= '0;
      l_ci_m1   <= '0;
      l_g_m1    <= '0;
      l_h_m1    <= '0;
      l_w_m1    <= '0;
      l_e_m1    <= '0;
      l_r       <= 5'(RST_R);
      l_s1      <= IB'(RST_S1);
      l_s2      <= IB'(RST_S2);
      l_s3c     <= IB'(RST_S3C);
      l_s4      <= IB'(RST_S4);
      l_gstep   <= IB'(RST_GSTEP);
      l_gstep_c <= IB'(RST_GSTEP_C);
      l_pn      <= IB'(1);
      l_pw      <= IB'(1);
      l_ph      <= IB'(1);
      l_pc      <= IB'(1);
      l_pg      <= IB'(1);
    end else if (accept && restart) begin
      l_wide    <= e_wide;
      l_dir     <= e_dir;
      l_co_m1   <= e_co_m1;
      l_ci_m1   <= e_ci_m1;
      l_g_m1    <= e_g_m1;
      l_h_m1    <= e_h_m1;
      l_w_m1    <= e_w_m1;
      l_e_m1    <= e_e_m1;
      l_r       <= e_r;
      l_s1      <= e_s1;
      l_s2      <= e_s2;
      l_s3c     <= e_s3c;
      l_s4      <= e_s4;
      l_gstep   <= e_gstep;
      l_gstep_c <= e_gstep_c;
      l_pn      <= e_pn;
      l_pw      <= e_pw;
      l_ph      <= e_ph;
      l_pc      <= e_pc;
      l_pg      <= e_pg;
    end
  end

  // ---------------- element counters and running indices ----------------
  // Each loop level keeps the index value at the start of its current pass.
  logic [11:0]   outch_ctr, chan_ctr, group_ctr;
  logic [7:0]    col_ctr, row_ctr;
  logic [4:0]    slot_ctr, mod_chan, mod_grp;
  logic [IB-1:0] fz_cur, fz_col, fz_row, fz_chan, fz_grp, fz_pack;
  logic [IB-1:0] pl_cur, pl_col, pl_row, pl_chan, pl_grp;

  logic [11:0]   st_outch, st_chan, st_group;
  logic [7:0]    st_col, st_row;
  logic [4:0]    st_slot, st_mod_chan, st_mod_grp;
  logic [IB-1:0] st_fz_cur, st_fz_col, st_fz_row, st_fz_chan, st_fz_grp, st_fz_pack;
  logic [IB-1:0] st_pl_cur, st_pl_col, st_pl_row, st_pl_chan, st_pl_grp;

  logic [11:0]   outch_ctr_next, chan_ctr_next, group_ctr_next;
  logic [7:0]    col_ctr_next, row_ctr_next;
  logic [4:0]    slot_ctr_next, mod_chan_next, mod_grp_next;
  logic [IB-1:0] fz_cur_next, fz_col_next, fz_row_next, fz_chan_next, fz_grp_next;
  logic [IB-1:0] fz_pack_next;
  logic [IB-1:0] pl_cur_next, pl_col_next, pl_row_next, pl_chan_next, pl_grp_next;

  logic          adv_n, adv_w, adv_h, adv_c, adv_g, last_elem;
  logic [4:0]    kmask;
  logic [5:0]    kval6, grp_sum;
  logic          grp_carry, chan_wrap;
  logic [IB-1:0] fz_n_add, fz_w_add, fz_h_add, fz_c_add, fz_g_add, fz_p_add;
  logic [IB-1:0] pl_n_add, pl_w_add, pl_h_add, pl_c_add, pl_g_add;

  always_comb begin
    st_outch    = restart ? '0 : outch_ctr;
    st_col      = restart ? '0 : col_ctr;
    st_row      = restart ? '0 : row_ctr;
    st_chan     = restart ? '0 : chan_ctr;
    st_group    = restart ? '0 : group_ctr;
    st_slot     = restart ? '0 : slot_ctr;
    st_mod_chan = restart ? '0 : mod_chan;
    st_mod_grp  = restart ? '0 : mod_grp;
    st_fz_cur   = restart ? '0 : fz_cur;
    st_fz_col   = restart ? '0 : fz_col;
    st_fz_row   = restart ? '0 : fz_row;
    st_fz_chan  = restart ? '0 : fz_chan;
    st_fz_grp   = restart ? '0 : fz_grp;
    st_fz_pack  = restart ? '0 : fz_pack;
    st_pl_cur   = restart ? '0 : pl_cur;
    st_pl_col   = restart ? '0 : pl_col;
    st_pl_row   = restart ? '0 : pl_row;
    st_pl_chan  = restart ? '0 : pl_chan;
    st_pl_grp   = restart ? '0 : pl_grp;
  end

  always_comb begin
    adv_n = st_outch != e_co_m1;
    adv_w = st_col != e_w_m1;
    adv_h = st_row != e_h_m1;
    adv_c = st_chan != e_ci_m1;
    adv_g = st_group != e_g_m1;
    last_elem = !adv_n && !adv_w && !adv_h && !adv_c && !adv_g;

    kmask     = e_wide ? 5'd31 : 5'd15;
    kval6     = e_wide ? 6'd32 : 6'd16;
    chan_wrap = st_mod_chan == kmask;
    // next group in the pack: input-channel offset grows by Cin, may carry a cube
    grp_sum   = {1'b0, st_mod_grp} + {1'b0, e_r};
    grp_carry = grp_sum >= kval6;

    fz_n_add = st_fz_cur + IB'(kval6);
    fz_w_add = st_fz_col + e_s1;
    fz_h_add = st_fz_row + e_s2;
    fz_c_add = st_fz_chan + (chan_wrap ? e_s3c : IB'(1));
    fz_g_add = st_fz_grp + (grp_carry ? e_gstep_c : e_gstep);
    fz_p_add = st_fz_pack + e_s4;
    pl_n_add = st_pl_cur + e_pn;
    pl_w_add = st_pl_col + e_pw;
    pl_h_add = st_pl_row + e_ph;
    pl_c_add = st_pl_chan + e_pc;
    pl_g_add = st_pl_grp + e_pg;

    outch_ctr_next = st_outch;
    col_ctr_next   = st_col;
    row_ctr_next   = st_row;
    chan_ctr_next  = st_chan;
    group_ctr_next = st_group;
    slot_ctr_next  = st_slot;
    mod_chan_next  = st_mod_chan;
    mod_grp_next   = st_mod_grp;
    fz_cur_next    = st_fz_cur;
    fz_col_next    = st_fz_col;
    fz_row_next    = st_fz_row;
    fz_chan_next   = st_fz_chan;
    fz_grp_next    = st_fz_grp;
    fz_pack_next   = st_fz_pack;
    pl_cur_next    = st_pl_cur;
    pl_col_next    = st_pl_col;
    pl_row_next    = st_pl_row;
    pl_chan_next   = st_pl_chan;
    pl_grp_next    = st_pl_grp;

    if (adv_n) begin
      outch_ctr_next = st_outch + 12'd1;
      fz_cur_next    = fz_n_add;
      pl_cur_next    = pl_n_add;
    end else if (adv_w) begin
      outch_ctr_next = '0;
      col_ctr_next   = st_col + 8'd1;
      fz_col_next    = fz_w_add;
      fz_cur_next    = fz_w_add;
      pl_col_next    = pl_w_add;
      pl_cur_next    = pl_w_add;
    end else if (adv_h) begin
      outch_ctr_next = '0;
      col_ctr_next   = '0;
      row_ctr_next   = st_row + 8'd1;
      fz_row_next    = fz_h_add;
      fz_col_next    = fz_h_add;
      fz_cur_next    = fz_h_add;
      pl_row_next    = pl_h_add;
      pl_col_next    = pl_h_add;
      pl_cur_next    = pl_h_add;
    end else if (adv_c) begin
      outch_ctr_next = '0;
      col_ctr_next   = '0;
      row_ctr_next   = '0;
      chan_ctr_next  = st_chan + 12'd1;
      mod_chan_next  = chan_wrap ? 5'd0 : st_mod_chan + 5'd1;
      fz_chan_next   = fz_c_add;
      fz_row_next    = fz_c_add;
      fz_col_next    = fz_c_add;
      fz_cur_next    = fz_c_add;
      pl_chan_next   = pl_c_add;
      pl_row_next    = pl_c_add;
      pl_col_next    = pl_c_add;
      pl_cur_next    = pl_c_add;
    end else if (adv_g) begin
      outch_ctr_next = '0;
      col_ctr_next   = '0;
      row_ctr_next   = '0;
      chan_ctr_next  = '0;
      group_ctr_next = st_group + 12'd1;
      if (st_slot != e_e_m1) begin
        slot_ctr_next = st_slot + 5'd1;
        mod_grp_next  = grp_carry ? 5'(grp_sum - kval6) : grp_sum[4:0];
        fz_grp_next   = fz_g_add;
      end else begin
        // pack is full: next group opens a new pack
        slot_ctr_next = '0;
        mod_grp_next  = '0;
        fz_pack_next  = fz_p_add;
        fz_grp_next   = fz_p_add;
      end
      mod_chan_next = mod_grp_next;
      fz_chan_next  = fz_grp_next;
      fz_row_next   = fz_grp_next;
      fz_col_next   = fz_grp_next;
      fz_cur_next   = fz_grp_next;
      pl_grp_next   = pl_g_add;
      pl_chan_next  = pl_g_add;
      pl_row_next   = pl_g_add;
      pl_col_next   = pl_g_add;
      pl_cur_next   = pl_g_add;
    end else begin
      outch_ctr_next = '0;
      col_ctr_next   = '0;
      row_ctr_next   = '0;
      chan_ctr_next  = '0;
      group_ctr_next = '0;
      slot_ctr_next  = '0;
      mod_chan_next  = '0;
      mod_grp_next   = '0;
      fz_cur_next    = '0;
      fz_col_next    = '0;
      fz_row_next    = '0;
      fz_chan_next   = '0;
      fz_grp_next    = '0;
      fz_pack_next   = '0;
      pl_cur_next    = '0;
      pl_col_next    = '0;
      pl_row_next    = '0;
      pl_chan_next   = '0;
      pl_grp_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outch_ctr <= '0;
      col_ctr   <= '0;
      row_ctr   <= '0;
      chan_ctr  <= '0;
      group_ctr <= '0;
      slot_ctr  <= '0;
      mod_chan  <= '0;
      mod_grp   <= '0;
      fz_cur    <= '0;
      fz_col    <= '0;
      fz_row    <= '0;
      fz_chan   <= '0;
      fz_grp    <= '0;
      fz_pack   <= '0;
      pl_cur    <= '0;
      pl_col    <= '0;
      pl_row    <= '0;
      pl_chan   <= '0;
      pl_grp    <= '0;
    end else if (accept) begin
      outch_ctr <= outch_ctr_next;
      col_ctr   <= col_ctr_next;
      row_ctr   <= row_ctr_next;
      chan_ctr  <= chan_ctr_next;
      group_ctr <= group_ctr_next;
      slot_ctr  <= slot_ctr_next;
      mod_chan  <= mod_chan_next;
      mod_grp   <= mod_grp_next;
      fz_cur    <= fz_cur_next;
      fz_col    <= fz_col_next;
      fz_row    <= fz_row_next;
      fz_chan   <= fz_chan_next;
      fz_grp    <= fz_grp_next;
      fz_pack   <= fz_pack_next;
      pl_cur    <= pl_cur_next;
      pl_col    <= pl_col_next;
      pl_row    <= pl_row_next;
      pl_chan   <= pl_chan_next;
      pl_grp    <= pl_grp_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata[31:0]  <= e_dir ? 32'(st_fz_cur) : 32'(st_pl_cur);
      m_axis_tdata[63:32] <= e_dir ? 32'(st_pl_cur) : 32'(st_fz_cur);
      m_axis_tlast        <= last_elem;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import gwfag_pkg::*;

  localparam logic [1:0] LAYOUT_NONE  = 2'd3;
  localparam logic [7:0] STEP_NEXT    = 8'h00;
  localparam logic [7:0] STEP_RESTART = 8'h01;

  typedef struct packed {
    logic [31:0] rd;
    logic [31:0] wr;
    logic        last;
  } index_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] restart, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [31:0] read_index, [63:32] write_index
  logic        m_axis_tlast;

  grouped_weight_fractal_address_gen_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // register copies, as written
  logic [12:0] r_out, r_in, r_groups;
  logic [7:0]  r_rows, r_cols;
  logic        r_wide, r_dir;
  logic [1:0]  r_layout;

  // shape latched at restart
  logic [63:0] sh_co, sh_ci, sh_h, sh_w, sh_g, sh_k;
  logic [1:0]  sh_lay;
  logic        sh_dir;
  logic [63:0] pack_span, st_col, st_row, st_c1, st_pack, n_total;

  // element position
  logic [63:0] grp_n, chan_n, row_n, col_n, och_n, slot_n, pack_n;

  logic [7:0]  item_q[$];
  index_pair_t pair_q[$];
  index_pair_t want;
  int          errors = 0;
  bit          no_gaps = 1'b0;

  function automatic logic [63:0] sat_count(input logic [12:0] v);
    return (v == 13'd0) ? 64'd1 : (v > COUNT_MAX) ? 64'(COUNT_MAX) : 64'(v);
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  task automatic latch_shape();
    logic [63:0] a, b, e, c1, cout_opt;
    sh_co  = sat_count(r_out);
    sh_ci  = sat_count(r_in);
    sh_h   = (r_rows == 0) ? 64'd1 : 64'(r_rows);
    sh_w   = (r_cols == 0) ? 64'd1 : 64'(r_cols);
    sh_g   = sat_count(r_groups);
    sh_k   = r_wide ? 64'd32 : 64'd16;
    sh_lay = r_layout;
    sh_dir = r_dir;
    // both factors are powers of two, so the lcm is just the larger one
    a = sh_k / gcd64(sh_ci, sh_k);
    b = 64'(OUT_CUBE) / gcd64(sh_co, 64'(OUT_CUBE));
    e = a / gcd64(a, b) * b;
    if (e > sh_g) e = sh_g;
    c1       = (e * sh_ci + sh_k - 1) / sh_k;
    cout_opt = (e * sh_co + OUT_CUBE - 1) / OUT_CUBE * OUT_CUBE;
    pack_span = e;
    st_col    = cout_opt * sh_k;
    st_row    = sh_w * st_col;
    st_c1     = sh_h * st_row;
    st_pack   = c1 * st_c1;
    n_total   = sh_g * sh_co;
  endtask

  task automatic zero_position();
    grp_n = 0; chan_n = 0; row_n = 0; col_n = 0; och_n = 0; slot_n = 0; pack_n = 0;
  endtask

  // works out the index pair of one item and steps to the next element
  task automatic predict_pair(input logic restart);
    logic [63:0] dst_ci, dst_co, src_co, fz, plain;
    index_pair_t p;
    if (restart) begin
      latch_shape();
      zero_position();
    end
    dst_ci = slot_n * sh_ci + chan_n;
    dst_co = slot_n * sh_co + och_n;
    src_co = grp_n * sh_co + och_n;
    fz = pack_n * st_pack + (dst_ci / sh_k) * st_c1 + row_n * st_row + col_n * st_col
       + dst_co * sh_k + dst_ci % sh_k;
    case (sh_lay)
      LAYOUT_HWCN: plain = ((row_n * sh_w + col_n) * sh_ci + chan_n) * n_total + src_co;
      LAYOUT_NCHW: plain = ((src_co * sh_ci + chan_n) * sh_h + row_n) * sh_w + col_n;
      LAYOUT_NHWC: plain = ((src_co * sh_h + row_n) * sh_w + col_n) * sh_ci + chan_n;
      default:     plain = 64'd0;
    endcase
    p.rd   = sh_dir ? fz[31:0] : plain[31:0];
    p.wr   = sh_dir ? plain[31:0] : fz[31:0];
    p.last = (och_n + 1 == sh_co) && (col_n + 1 == sh_w) && (row_n + 1 == sh_h)
          && (chan_n + 1 == sh_ci) && (grp_n + 1 == sh_g);
    pair_q.push_back(p);

    if (och_n + 1 < sh_co) begin
      och_n++;
    end else if (col_n + 1 < sh_w) begin
      och_n = 0; col_n++;
    end else if (row_n + 1 < sh_h) begin
      och_n = 0; col_n = 0; row_n++;
    end else if (chan_n + 1 < sh_ci) begin
      och_n = 0; col_n = 0; row_n = 0; chan_n++;
    end else if (grp_n + 1 < sh_g) begin
      och_n = 0; col_n = 0; row_n = 0; chan_n = 0; grp_n++;
      if (slot_n + 1 < pack_span) begin
        slot_n++;
      end else begin
        slot_n = 0; pack_n++;
      end
    end else begin
      zero_position();
    end
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, got_v);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_OUT_PER_GROUP: r_out    = val;
      REG_IN_CHANNELS:   r_in     = val;
      REG_KERNEL_ROWS:   r_rows   = val[7:0];
      REG_KERNEL_COLS:   r_cols   = val[7:0];
      REG_GROUP_COUNT:   r_groups = val;
      REG_WIDE_CUBE:     r_wide   = val[0];
      REG_PLAIN_LAYOUT:  r_layout = val[1:0];
      REG_DIRECTION:     r_dir    = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_shape(input logic [12:0] co, input logic [12:0] ci,
                             input logic [7:0] h, input logic [7:0] w,
                             input logic [12:0] g, input logic wide,
                             input logic [1:0] lay, input logic dir);
    write_reg(REG_OUT_PER_GROUP, co);
    write_reg(REG_IN_CHANNELS, ci);
    write_reg(REG_KERNEL_ROWS, 13'(h));
    write_reg(REG_KERNEL_COLS, 13'(w));
    write_reg(REG_GROUP_COUNT, g);
    write_reg(REG_WIDE_CUBE, 13'(wide));
    write_reg(REG_PLAIN_LAYOUT, 13'(lay));
    write_reg(REG_DIRECTION, 13'(dir));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (item_q.size() != 0 || s_axis_tvalid || pair_q.size() != 0);
  endtask

  task automatic queue_run(input int n, input bit lead_restart);
    for (int i = 0; i < n; i++) begin
      if (i == 0 ? lead_restart : ($urandom_range(99) < 3))
        item_q.push_back(STEP_RESTART);
      else
        item_q.push_back(STEP_NEXT);
    end
  endtask

  // mostly tiny counts so whole transfers finish; now and then an extreme
  function automatic logic [12:0] pick_count();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return $urandom_range(1) ? 13'd0 : 13'($urandom_range(4096, 8191));
    if (r < 5)  return 13'($urandom_range(1, 40));
    return 13'($urandom_range(1, 4));
  endfunction

  function automatic logic [7:0] pick_dim();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return $urandom_range(1) ? 8'd0 : 8'd255;
    return 8'($urandom_range(1, 3));
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_pair(s_axis_tdata[0]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (item_q.size() != 0 && (no_gaps || $urandom_range(99) >= 22)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= item_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 22);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pair_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = pair_q.pop_front();
          if (m_axis_tdata[31:0] !== want.rd) note_mismatch("read_index", want.rd,
                                                            m_axis_tdata[31:0]);
          if (m_axis_tdata[63:32] !== want.wr) note_mismatch("write_index", want.wr,
                                                             m_axis_tdata[63:32]);
          if (m_axis_tlast !== want.last) note_mismatch("last", 32'(want.last),
                                                        32'(m_axis_tlast));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    r_out = 13'd1; r_in = 13'd1; r_rows = 8'd1; r_cols = 8'd1; r_groups = 13'd1;
    r_wide = 1'b0; r_layout = LAYOUT_NCHW; r_dir = 1'b0;
    latch_shape();
    zero_position();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default shape: a single element, so every item is last
    item_q.push_back(STEP_NEXT);
    item_q.push_back(STEP_NEXT);
    item_q.push_back(STEP_RESTART);
    wait_drained();

    // new shape is ignored until restart; then run past the end to see the wrap
    apply_shape(13'd2, 13'd1, 8'd1, 8'd2, 13'd2, 1'b1, LAYOUT_HWCN, 1'b0);
    item_q.push_back(STEP_NEXT);
    item_q.push_back(STEP_NEXT);
    queue_run(10, 1'b1);
    wait_drained();

    // zero sizes, oversized counts, unknown layout, reversed direction
    apply_shape(13'd0, 13'd8191, 8'd0, 8'd0, 13'd5000, 1'b0, LAYOUT_NONE, 1'b1);
    queue_run(4, 1'b1);
    wait_drained();

    apply_shape(13'd4096, 13'd4096, 8'd255, 8'd255, 13'd4096, 1'b1, LAYOUT_NHWC, 1'b1);
    queue_run(3, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      apply_shape(pick_count(), pick_count(), pick_dim(), pick_dim(), pick_count(),
                  1'($urandom_range(1)), 2'($urandom_range(3)), 1'($urandom_range(1)));
      queue_run(60, $urandom_range(99) < 85);
      wait_drained();
      if (ph == 5) begin
        // plain index overflows 32 bits from the second column of the second row on; no idling here
        no_gaps = 1'b1;
        apply_shape(13'd1, 13'd4096, 8'd2, 8'd255, 13'd4096, 1'b0, LAYOUT_HWCN, 1'b0);
        queue_run(300, 1'b1);
        wait_drained();
        no_gaps = 1'b0;
      end
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && pair_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gwfag_pkg.sv
rtl/grouped_weight_fractal_address_gen_unit.sv
tb/sv/tb_top.sv
